/* design/mks_pkg.sv */
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants for the matrix keypad scanner
// Register map, scan phase encoding, configuration bundle and the key table.
// ----------------------------------------------------------------------------
package mks_pkg;

  localparam int unsigned SettleW    = 19;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 32;

  localparam logic [SettleW-1:0] SettleReset = 19'd417000;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_SETTLE      = 3'd0,
    REG_CODE_UP     = 3'd1,
    REG_CODE_DOWN   = 3'd2,
    REG_CODE_ENTER  = 3'd3,
    REG_CODE_DELETE = 3'd4
  } reg_idx_t;

  typedef enum logic {
    PH_SCAN    = 1'b0,
    PH_RELEASE = 1'b1
  } phase_t;

  typedef struct packed {
    logic [SettleW-1:0] settle_ticks;
    logic [CodeW-1:0]   code_up;
    logic [CodeW-1:0]   code_down;
    logic [CodeW-1:0]   code_enter;
    logic [CodeW-1:0]   code_delete;
  } cfg_t;

  // fixed legend of the keypad; column 3 comes from registers
  function automatic logic [CodeW-1:0] key_lookup(input logic [1:0] row,
                                                  input logic [1:0] col,
                                                  input cfg_t       cfg);
    logic [CodeW-1:0] code;
    code = '0;
    case ({row, col})
      4'b00_00: code = 8'h31;  // '1'
      4'b00_01: code = 8'h32;  // '2'
      4'b00_10: code = 8'h33;  // '3'
      4'b00_11: code = cfg.code_up;
      4'b01_00: code = 8'h34;  // '4'
      4'b01_01: code = 8'h35;  // '5'
      4'b01_10: code = 8'h36;  // '6'
      4'b01_11: code = cfg.code_down;
      4'b10_00: code = 8'h37;  // '7'
      4'b10_01: code = 8'h38;  // '8'
      4'b10_10: code = 8'h39;  // '9'
      4'b10_11: code = cfg.code_enter;
      4'b11_00: code = 8'h30;  // '0'
      4'b11_01: code = 8'h2E;  // '.'
      4'b11_10: code = 8'h2D;  // '-'
      4'b11_11: code = cfg.code_delete;
      default:  code = '0;
    endcase
    return code;
  endfunction

endpackage

/* design/mks_regs.sv */
// ----------------------------------------------------------------------------
// mks_regs: configuration register file
// APB-style slave holding the settle time and the four programmable key codes.
// ----------------------------------------------------------------------------
module mks_regs
  import mks_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SETTLE:      cfg_nxt.settle_ticks = pwdata[SettleW-1:0];
        REG_CODE_UP:     cfg_nxt.code_up      = pwdata[CodeW-1:0];
        REG_CODE_DOWN:   cfg_nxt.code_down    = pwdata[CodeW-1:0];
        REG_CODE_ENTER:  cfg_nxt.code_enter   = pwdata[CodeW-1:0];
        REG_CODE_DELETE: cfg_nxt.code_delete  = pwdata[CodeW-1:0];
        default:         cfg_nxt = cfg_r;  // unmapped, drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks <= SettleReset;
      cfg_r.code_up      <= '0;
      cfg_r.code_down    <= '0;
      cfg_r.code_enter   <= '0;
      cfg_r.code_delete  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SETTLE:      prdata = {{(DataW-SettleW){1'b0}}, cfg_r.settle_ticks};
      REG_CODE_UP:     prdata = {{(DataW-CodeW){1'b0}}, cfg_r.code_up};
      REG_CODE_DOWN:   prdata = {{(DataW-CodeW){1'b0}}, cfg_r.code_down};
      REG_CODE_ENTER:  prdata = {{(DataW-CodeW){1'b0}}, cfg_r.code_enter};
      REG_CODE_DELETE: prdata = {{(DataW-CodeW){1'b0}}, cfg_r.code_delete};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* design/matrix_keypad_scanner.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_scanner: 4x4 keypad column scanner with release detection
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_row_levels[3:0]
//   out_    | output    | out_valid/out_stall| out_drive_column, out_key_valid,
//           |           |                    | out_key_code
//   cfg     | input     | APB psel/penable   | paddr[4:0], pwdata/prdata[31:0]
//
// One item per cycle while in_stall is low: scan state and result are both
// registered at the accepting edge, and offered from the next cycle on.
// Throughput is set by the single next-state step plus the output register.
// A held result stalls the input only while out_stall is high.
// Synchronous reset clears the scan state and output valid and loads the register defaults.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
  import mks_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [3:0]       in_row_levels,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_drive_column,
  output logic             out_key_valid,
  output logic [CodeW-1:0] out_key_code,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  mks_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phase_t             phase_r,  phase_nxt;
  logic [1:0]         col_r,    col_nxt;
  logic [1:0]         row_r,    row_nxt;
  logic [SettleW-1:0] wait_r,   wait_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_col_r;
  logic               out_kv_r;
  logic [CodeW-1:0]   out_code_r;

  logic               accept;
  logic               hit;
  logic [1:0]         hit_row;
  logic               release_seen;
  logic               key_valid;
  logic [CodeW-1:0]   key_code;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // priority pick of the lowest pressed row
  always_comb begin
    hit     = ~&in_row_levels;
    hit_row = 2'd3;
    if (!in_row_levels[2]) hit_row = 2'd2;
    if (!in_row_levels[1]) hit_row = 2'd1;
    if (!in_row_levels[0]) hit_row = 2'd0;
  end

  assign release_seen = in_row_levels[row_r];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    wait_nxt  = wait_r;
    case (phase_r)
      PH_SCAN: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
          if (wait_r == SettleW'(1)) col_nxt = col_r + 1'b1;
        end else if (hit) begin
          row_nxt   = hit_row;
          phase_nxt = PH_RELEASE;
        end else if (cfg.settle_ticks == '0) begin
          col_nxt = col_r + 1'b1;
        end else begin
          wait_nxt = cfg.settle_ticks;
        end
      end
      PH_RELEASE: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else if (release_seen) begin
          phase_nxt = PH_SCAN;
          col_nxt   = 2'd0;
        end else begin
          wait_nxt = cfg.settle_ticks;
        end
      end
      default: phase_nxt = PH_SCAN;
    endcase
  end

  // result of this tick
  always_comb begin
    key_valid = 1'b0;
    key_code  = '0;
    case (phase_r)
      PH_RELEASE: begin
        if (wait_r == '0 && release_seen) begin
          key_valid = 1'b1;
          key_code  = key_lookup(row_r, col_r, cfg);
        end
      end
      default: begin
        key_valid = 1'b0;
        key_code  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      col_r   <= '0;
      row_r   <= '0;
      wait_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_col_r  <= col_nxt;
      out_kv_r   <= key_valid;
      out_code_r <= key_code;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_column = out_col_r;
  assign out_key_valid    = out_kv_r;
  assign out_key_code     = out_code_r;

  // a release restarts the scan at column 0
  a_release_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kv_r) |-> (out_col_r == 2'd0))
    else $error("key reported with nonzero drive column");

  a_idle_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kv_r) |-> (out_code_r == '0))
    else $error("key code set without key valid");

  a_release_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_RELEASE && wait_r == '0 && release_seen)
      |=> (phase_r == PH_SCAN && col_r == 2'd0))
    else $error("release not followed by scan restart");

endmodule

/* sim/matrix_keypad_scanner_tb.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_tb: self-checking bench for the 4x4 keypad scanner
// Drives row samples from a simulated keypad that follows the driven column,
// predicts each result tick in a scoreboard and compares every output field.
// Register settings change between phases, from zero settle time to maximum.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_tb
  import mks_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Limit       = 400000;
  localparam int unsigned IdleCycles  = 4;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 260;
  localparam int unsigned RegUnmapped = 5;
  localparam int unsigned RegSlots    = 1 << (AddrW - 2);

  typedef struct {
    logic [1:0]       drive_column;
    logic             key_valid;
    logic [CodeW-1:0] key_code;
  } key_result_t;

  class scan_scoreboard;
    logic [SettleW-1:0] settle;
    logic [CodeW-1:0]   col3_code [4];
    phase_t             phase;
    logic [1:0]         column;
    logic [1:0]         held_row;
    logic [SettleW-1:0] countdown;
    key_result_t        pending_results [$];
    int unsigned        errors;

    function new();
      settle    = SettleReset;
      col3_code = '{default: '0};
      phase     = PH_SCAN;
      column    = '0;
      held_row  = '0;
      countdown = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_register(int unsigned idx, logic [DataW-1:0] value);
      case (idx)
        REG_SETTLE:      settle       = value[SettleW-1:0];
        REG_CODE_UP:     col3_code[0] = value[CodeW-1:0];
        REG_CODE_DOWN:   col3_code[1] = value[CodeW-1:0];
        REG_CODE_ENTER:  col3_code[2] = value[CodeW-1:0];
        REG_CODE_DELETE: col3_code[3] = value[CodeW-1:0];
        default: ;
      endcase
    endfunction

    function logic [CodeW-1:0] key_code_of(logic [1:0] row, logic [1:0] col);
      string legend;
      if (col == 2'd3) return col3_code[row];
      case (row)
        2'd0:    legend = "123";
        2'd1:    legend = "456";
        2'd2:    legend = "789";
        default: legend = "0.-";
      endcase
      return legend[col];
    endfunction

    // advance the scan state by one accepted sample and queue its result
    function void note_rows(logic [3:0] rows);
      key_result_t want;
      bit          found;
      want.key_valid = 1'b0;
      want.key_code  = '0;
      if (phase == PH_SCAN) begin
        if (countdown != 0) begin
          countdown--;
          if (countdown == 0) column++;
        end else if (rows != 4'hF) begin
          found = 0;
          for (int r = 0; r < 4; r++) begin
            if (!found && !rows[r]) begin
              held_row = 2'(r);
              found    = 1;
            end
          end
          phase = PH_RELEASE;
        end else if (settle == 0) begin
          column++;
        end else begin
          countdown = settle;
        end
      end else begin
        if (countdown != 0) begin
          countdown--;
        end else if (rows[held_row]) begin
          want.key_valid = 1'b1;
          want.key_code  = key_code_of(held_row, column);
          phase          = PH_SCAN;
          column         = '0;
        end else begin
          countdown = settle;
        end
      end
      want.drive_column = column;
      pending_results.push_back(want);
    endfunction

    task check_result(logic [1:0] col, logic kv, logic [CodeW-1:0] code);
      key_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result column=%0d valid=%0b code=%02h", col, kv, code));
        return;
      end
      want = pending_results.pop_front();
      if (col !== want.drive_column)
        report($sformatf("drive_column %0d, want %0d", col, want.drive_column));
      if (kv !== want.key_valid)
        report($sformatf("key_valid %0b, want %0b", kv, want.key_valid));
      if (code !== want.key_code)
        report($sformatf("key_code %02h, want %02h", code, want.key_code));
    endtask
  endclass

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic [3:0]       in_row_levels = 4'hF;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [1:0]       out_drive_column;
  logic             out_key_valid;
  logic [CodeW-1:0] out_key_code;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  scan_scoreboard sb;
  bit             idle_on   = 1'b1;
  bit             hold_req  = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    cycle_count = 0;

  matrix_keypad_scanner u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_levels    (in_row_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive_column (out_drive_column),
    .out_key_valid    (out_key_valid),
    .out_key_code     (out_key_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  // one sample transfer; returns at the accepting edge
  task automatic send_item(input logic [3:0] levels);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_row_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rows(levels);
    items_sent++;
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic settle_to_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [DataW-1:0] value);
    settle_to_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
  endtask

  task automatic set_all(input logic [DataW-1:0] settle, input logic [DataW-1:0] c_up,
                         input logic [DataW-1:0] c_dn, input logic [DataW-1:0] c_ent,
                         input logic [DataW-1:0] c_del);
    write_reg(REG_SETTLE, settle);
    write_reg(REG_CODE_UP, c_up);
    write_reg(REG_CODE_DOWN, c_dn);
    write_reg(REG_CODE_ENTER, c_ent);
    write_reg(REG_CODE_DELETE, c_del);
  endtask

  // simulated key held until the scanner latches it, then released
  task automatic press_and_release(input int r, input int c, input bit chord,
                                   input bit bounce);
    logic [3:0]  held [4];
    logic [3:0]  lv;
    int unsigned n;
    int unsigned cap;
    held = '{default: 4'h0};
    held[c][r] = 1'b1;
    if (chord) held[$urandom_range(3)][$urandom_range(3)] = 1'b1;
    cap = 4 * (sb.settle + 2) + 8;
    n = 0;
    while (sb.phase == PH_SCAN && n < cap) begin
      send_item(~held[sb.column]);
      n++;
    end
    repeat ($urandom_range(4)) send_item(~held[sb.column]);
    cap = 8 * (sb.settle + 2) + 8;
    n = 0;
    while (sb.phase == PH_RELEASE && n < cap) begin
      lv = $urandom_range(1) ? 4'hF : 4'($urandom);
      if (!(bounce && $urandom_range(3) == 0)) lv[sb.held_row] = 1'b1;
      send_item(lv);
      n++;
    end
  endtask

  task automatic random_episode();
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      press_and_release($urandom_range(3), $urandom_range(3), $urandom_range(4) == 0,
                        $urandom_range(2) == 0);
    end else if (kind < 85) begin
      repeat ($urandom_range(8, 1)) send_item(4'($urandom));
    end else begin
      // key let go before the scan reaches it
      repeat ($urandom_range(3, 1)) send_item(4'($urandom));
      repeat ($urandom_range(6, 1)) send_item(4'hF);
    end
  endtask

  // sample that never loads a wait: hit on every scan, release on every poll
  task automatic no_wait_item();
    logic [3:0] lv;
    lv = 4'($urandom);
    if (sb.countdown == 0) begin
      if (sb.phase == PH_SCAN) begin
        while (lv == 4'hF) lv = 4'($urandom);
      end else begin
        lv[sb.held_row] = 1'b1;
      end
    end
    send_item(lv);
  endtask

  task automatic random_phase();
    int unsigned start;
    start = items_sent;
    while (items_sent - start < PhaseItems) random_episode();
    // leave a wait running across the next register write
    repeat (3) send_item(4'hF);
  endtask

  // result side: checks transfers and throttles with out_stall
  initial begin
    int unsigned hold_left;
    logic        stall_next;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_drive_column, out_key_valid, out_key_code);
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HoldCycles;
        stall_next = 1'b1;
      end else begin
        stall_next = idle_on && ($urandom_range(99) < 28);
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    while (cycle_count < Limit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[matrix_keypad_scanner] ERROR");
    $finish;
  end

  initial begin
    int unsigned start;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settle time: every scan hits in column 0, every poll reads released
    send_item(4'b1110); send_item(4'b1111);
    send_item(4'b1101); send_item(4'b0010);
    send_item(4'b1011); send_item(4'b0100);
    send_item(4'b0111); send_item(4'b1000);
    send_item(4'b0000); send_item(4'b1111);
    send_item(4'b0011); send_item(4'b0100);

    // zero settle time: column steps every tick until a key is seen, column 3 uses reset codes
    write_reg(REG_SETTLE, 32'd0);
    press_and_release(0, 3, 1'b0, 1'b1);
    press_and_release(3, 3, 1'b0, 1'b0);
    press_and_release(1, 1, 1'b0, 1'b1);

    // writes beyond the register map are dropped
    for (int unsigned i = RegUnmapped; i < RegSlots; i++) write_reg(i, $urandom);

    set_all(32'd0, $urandom, $urandom, $urandom, $urandom);
    random_phase();

    set_all(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase();

    set_all(32'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase();

    set_all($urandom_range(6, 3), $urandom, $urandom, $urandom, $urandom);
    idle_on = 1'b0;
    random_phase();
    idle_on = 1'b1;

    set_all(32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom);
    start = items_sent;
    while (items_sent - start < PhaseItems / 2) no_wait_item();

    set_all($urandom_range(40, 8), $urandom, $urandom, $urandom, $urandom);
    hold_req = 1'b1;
    random_phase();

    set_all(32'd0, $urandom, $urandom, $urandom, $urandom);
    start = items_sent;
    while (items_sent - start < PhaseItems / 2) random_episode();
    settle_to_idle();
    while (items_sent - start < PhaseItems) random_episode();

    settle_to_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[matrix_keypad_scanner] OK");
    end else begin
      $display("[matrix_keypad_scanner] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mks_pkg.sv
design/mks_regs.sv
design/matrix_keypad_scanner.sv
sim/matrix_keypad_scanner_tb.sv
